// ===== design/sapq_pkg.sv =====
// Package for the sorted array priority queue.
// Holds field widths, operation codes, the controller state type and the
// command and status structs. It depends on nothing.
package sapq_pkg;

  localparam int unsigned DepthDef = 8;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned PayW     = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncRemove = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_OUT  = 2'b10
  } state_e;

  typedef struct packed {
    logic load;
    logic insert;
    logic remove;
    logic ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } status_t;

endpackage

// ===== design/sapq_ctrl.sv =====
// Controller of the sorted array priority queue: handshakes and command decode.
// Depends on sapq_pkg.
module sapq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_func_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sapq_pkg::status_t status_i,
  output sapq_pkg::cmd_t    cmd_o
);
  import sapq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign out_valid_o = (state_q == ST_OUT);
  assign in_ready_o  = !out_valid_o || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (accept) state_d = ST_OUT;
        else if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.insert = accept && (in_func_i == FuncInsert) && !status_i.full;
    cmd_o.remove = accept && (in_func_i == FuncRemove) && !status_i.empty;
    cmd_o.ok     = cmd_o.insert || cmd_o.remove;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/sapq_dp.sv =====
// Datapath of the sorted array priority queue: slot row, entry count, result register.
// Slots are kept in descending priority order with the top entry in slot 0.
// Depends on sapq_pkg.
module sapq_dp #(
  parameter int unsigned DEPTH = sapq_pkg::DepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sapq_pkg::cmd_t                 cmd_i,
  input  logic signed [sapq_pkg::PrioW-1:0] prio_i,
  input  logic [sapq_pkg::PayW-1:0]      payload_i,
  output sapq_pkg::status_t              status_o,
  output logic                           res_ok_o,
  output logic [sapq_pkg::CountW-1:0]    res_count_o,
  output logic                           res_full_o,
  output logic                           res_empty_o,
  output logic signed [sapq_pkg::PrioW-1:0] res_prio_o,
  output logic [sapq_pkg::PayW-1:0]      res_payload_o
);
  import sapq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic signed [PrioW-1:0] prio_q [DEPTH];
  logic signed [PrioW-1:0] prio_d [DEPTH];
  logic [PayW-1:0]         pay_q  [DEPTH];
  logic [PayW-1:0]         pay_d  [DEPTH];
  logic [DEPTH-1:0]        ge;
  logic [CntW-1:0]         count_q, count_d;

  assign status_o.full  = (count_q == DepthC);
  assign status_o.empty = (count_q == '0);

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      ge[j] = (CntW'(j) < count_q) && (prio_q[j] >= prio_i);
    end
  end

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      prio_d[j] = prio_q[j];
      pay_d[j]  = pay_q[j];
      if (cmd_i.insert && !ge[j]) begin
        if (j == 0) begin
          prio_d[j] = prio_i;
          pay_d[j]  = payload_i;
        end else if (ge[j-1]) begin
          prio_d[j] = prio_i;
          pay_d[j]  = payload_i;
        end else begin
          prio_d[j] = prio_q[j-1];
          pay_d[j]  = pay_q[j-1];
        end
      end else if (cmd_i.remove && (j + 1 < DEPTH)) begin
        prio_d[j] = prio_q[j+1];
        pay_d[j]  = pay_q[j+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) count_d = count_q + CntW'(1);
    else if (cmd_i.remove) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DEPTH; j++) begin
      prio_q[j] <= prio_d[j];
      pay_q[j]  <= pay_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_ok_o    <= cmd_i.ok;
      res_count_o <= CountW'({{CountW{1'b0}}, count_d});
      res_full_o  <= (count_d == DepthC);
      res_empty_o <= (count_d == '0);
      if (count_d == '0) begin
        res_prio_o    <= '0;
        res_payload_o <= '0;
      end else begin
        res_prio_o    <= prio_d[0];
        res_payload_o <= pay_d[0];
      end
    end
  end

endmodule

// ===== design/sorted_array_priority_queue.sv =====
// The result of an accepted request beat is held in the datapath's result register while the controller is in ST_OUT.
// Throughput: one request per cycle while each result beat is taken; every slot compares and shifts in parallel.
// A new request is taken while the result waits whenever the result is taken too.
// Reset clears the entry count and the output valid; slot contents are not reset.
// Depends on sapq_pkg, sapq_ctrl and sapq_dp.
module sorted_array_priority_queue #(
  parameter int unsigned DEPTH = sapq_pkg::DepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: priority_req [15:0], payload [23:16].
  input  logic [sapq_pkg::InDataW-1:0]     s_axis_tdata,
  // Fields from bit 0: func.
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: ok, count [4:1], is_full, is_empty, top_priority [22:7],
  // top_payload [30:23], zero fill.
  output logic [sapq_pkg::OutDataW-1:0]    m_axis_tdata
);
  import sapq_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic                    res_ok, res_full, res_empty;
  logic [CountW-1:0]       res_count;
  logic signed [PrioW-1:0] res_prio;
  logic [PayW-1:0]         res_payload;

  sapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sapq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .prio_i        (s_axis_tdata[PrioW-1:0]),
    .payload_i     (s_axis_tdata[PrioW+PayW-1:PrioW]),
    .status_o      (status),
    .res_ok_o      (res_ok),
    .res_count_o   (res_count),
    .res_full_o    (res_full),
    .res_empty_o   (res_empty),
    .res_prio_o    (res_prio),
    .res_payload_o (res_payload)
  );

  assign m_axis_tdata = {1'b0, res_payload, res_prio, res_empty, res_full, res_count, res_ok};

endmodule

// ===== design/sapq_checker.sv =====
// Port-level checker for the sorted array priority queue, bound to the top level.
// Depends on sapq_pkg and sorted_array_priority_queue.
module sapq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sapq_pkg::OutDataW-1:0] m_axis_tdata
);
  import sapq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result beat changed while stalled.");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Request not taken while the result side is free.");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("No result beat after an accepted request beat.");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6] == (m_axis_tdata[4:1] == 4'd0)))
    else $error("Empty flag disagrees with count.");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> (m_axis_tdata[30:7] == 24'd0))
    else $error("Top entry is not zero on an empty queue.");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
